// ----- hdl/ihcv_pkg.sv -----
// Shared constants for the image header CRC verifier.
`timescale 1ns / 1ps

package ihcv_pkg;

  localparam logic [31:0] ALL_ONES     = 32'hffff_ffff;
  localparam logic [31:0] CRC_POLY     = 32'hedb8_8320;
  localparam logic [31:0] HDR_SIZE     = 32'd36;
  localparam logic [5:0]  HDR_LAST_IDX = 6'd35;
  localparam logic [5:0]  HDR_CRC_SPAN = 6'd32;

  // Phase codes.
  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_DISCARD = 2'd2;

  // Status codes.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_HDR_SHORT  = 3'd1;
  localparam logic [2:0] ST_HDR_LEN    = 3'd2;
  localparam logic [2:0] ST_HDR_CRC    = 3'd3;
  localparam logic [2:0] ST_DATA_LEN   = 3'd4;
  localparam logic [2:0] ST_DATA_CRC   = 3'd5;

  // Header word positions (byte offset / 4).
  localparam logic [3:0] W_LEN     = 4'd1;
  localparam logic [3:0] W_CUST    = 4'd2;
  localparam logic [3:0] W_PROD    = 4'd3;
  localparam logic [3:0] W_VER     = 4'd4;
  localparam logic [3:0] W_BUILD   = 4'd5;
  localparam logic [3:0] W_DLEN    = 4'd6;
  localparam logic [3:0] W_DCRC    = 4'd7;
  localparam logic [3:0] W_HCRC    = 4'd8;

endpackage

// ----- hdl/ihcv_crc_step.sv -----
// One byte step of the reflected CRC-32.
`timescale 1ns / 1ps

module ihcv_crc_step (
  input  logic [31:0] crc_in,
  input  logic [7:0]  data,
  output logic [31:0] crc_out
);

  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ ihcv_pkg::CRC_POLY) : (c >> 1);
    end
    crc_out = c;
  end

endmodule

// ----- hdl/image_header_crc_verifier.sv -----
// Top level of the image header CRC verifier.
// An accepted input item passes through the input register and then the result register.
// Throughput: one byte per cycle while the output takes results; the byte-wide CRC step
// sits between the input register and the result register.
// Bytes that produce no result leave the input register without waiting on the output.
// Reset (rst, synchronous) returns to the header phase with an empty pipeline.
`timescale 1ns / 1ps

module image_header_crc_verifier (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tlast,   // end_of_image
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [7:0] payload_byte, [10:8] status, [42:11] customer_code,
  // [74:43] product_code, [106:75] version_word, [138:107] build_stamp, rest zero
  output logic [143:0] m_axis_tdata,
  output logic         m_axis_tuser,   // payload_valid
  output logic         m_axis_tlast    // done_res
);

  // Input register.
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // Block state.
  logic [31:0] crc, crc_next;
  logic [31:0] byte_count, count_next;
  logic [1:0]  phase, phase_next;
  logic [2:0]  err, err_next;

  // Header words (no reset needed; only read once written).
  logic [31:0] hlen, cust, prod, ver, build, dlen, dcrc, hcrc;
  logic [31:0] hlen_next, cust_next, prod_next, ver_next, build_next;
  logic [31:0] dlen_next, dcrc_next, hcrc_next;

  logic [31:0]  crc_step;
  logic         proc, proc_res, out_free;
  logic [2:0]   res_status;
  logic         res_fields;
  logic [143:0] res_data;
  logic [5:0]   idx;

  function automatic logic [31:0] set_byte(input logic [31:0] w, input logic [1:0] lane,
                                           input logic [7:0] b);
    logic [31:0] r;
    r = w;
    unique case (lane)
      2'd0:    r[7:0]   = b;
      2'd1:    r[15:8]  = b;
      2'd2:    r[23:16] = b;
      default: r[31:24] = b;
    endcase
    return r;
  endfunction

  ihcv_crc_step u_crc_step (
    .crc_in  (crc),
    .data    (in_byte),
    .crc_out (crc_step)
  );

  assign idx      = byte_count[5:0];
  assign proc_res = in_valid && (phase == ihcv_pkg::PH_PAYLOAD || in_last);
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign proc     = in_valid && (!proc_res || out_free);
  assign s_axis_tready = !in_valid || proc;

  always_comb begin
    crc_next   = crc;
    phase_next = phase;
    err_next   = err;
    hlen_next  = hlen;
    cust_next  = cust;
    prod_next  = prod;
    ver_next   = ver;
    build_next = build;
    dlen_next  = dlen;
    dcrc_next  = dcrc;
    hcrc_next  = hcrc;
    count_next = (&byte_count) ? byte_count : byte_count + 32'd1;

    if (phase == ihcv_pkg::PH_HEADER) begin
      unique case (idx[5:2])
        ihcv_pkg::W_LEN:   hlen_next  = set_byte(hlen, idx[1:0], in_byte);
        ihcv_pkg::W_CUST:  cust_next  = set_byte(cust, idx[1:0], in_byte);
        ihcv_pkg::W_PROD:  prod_next  = set_byte(prod, idx[1:0], in_byte);
        ihcv_pkg::W_VER:   ver_next   = set_byte(ver, idx[1:0], in_byte);
        ihcv_pkg::W_BUILD: build_next = set_byte(build, idx[1:0], in_byte);
        ihcv_pkg::W_DLEN:  dlen_next  = set_byte(dlen, idx[1:0], in_byte);
        ihcv_pkg::W_DCRC:  dcrc_next  = set_byte(dcrc, idx[1:0], in_byte);
        ihcv_pkg::W_HCRC:  hcrc_next  = set_byte(hcrc, idx[1:0], in_byte);
        default: ;  // magic word is not kept
      endcase
      if (idx < ihcv_pkg::HDR_CRC_SPAN) begin
        crc_next = crc_step;
      end
      if (idx == ihcv_pkg::HDR_LAST_IDX) begin
        // The last header byte completes the stored header CRC on the fly.
        priority if (hlen != ihcv_pkg::HDR_SIZE) begin
          err_next = ihcv_pkg::ST_HDR_LEN;
        end else if ((crc ^ ihcv_pkg::ALL_ONES) != {in_byte, hcrc[23:0]}) begin
          err_next = ihcv_pkg::ST_HDR_CRC;
        end else begin
          err_next = ihcv_pkg::ST_OK;
        end
        crc_next   = ihcv_pkg::ALL_ONES;
        phase_next = (err_next != ihcv_pkg::ST_OK) ? ihcv_pkg::PH_DISCARD
                                                   : ihcv_pkg::PH_PAYLOAD;
      end
    end else if (phase == ihcv_pkg::PH_PAYLOAD) begin
      crc_next = crc_step;
    end

    // Verdict for an end mark, taken on the updated state.
    res_fields = 1'b1;
    priority if (phase_next == ihcv_pkg::PH_HEADER) begin
      res_status = ihcv_pkg::ST_HDR_SHORT;
      res_fields = 1'b0;
    end else if (err_next != ihcv_pkg::ST_OK) begin
      res_status = err_next;
    end else if ((count_next - 32'd35) != dlen_next) begin
      res_status = ihcv_pkg::ST_DATA_LEN;
    end else if ((crc_next ^ ihcv_pkg::ALL_ONES) != dcrc_next) begin
      res_status = ihcv_pkg::ST_DATA_CRC;
    end else begin
      res_status = ihcv_pkg::ST_OK;
    end

    res_data      = '0;
    res_data[7:0] = (phase == ihcv_pkg::PH_PAYLOAD) ? in_byte : 8'd0;
    if (in_last) begin
      res_data[10:8] = res_status;
      if (res_fields) begin
        res_data[42:11]   = cust;
        res_data[74:43]   = prod;
        res_data[106:75]  = ver;
        res_data[138:107] = build;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc        <= ihcv_pkg::ALL_ONES;
      byte_count <= 32'd0;
      phase      <= ihcv_pkg::PH_HEADER;
      err        <= ihcv_pkg::ST_OK;
    end else if (proc) begin
      if (in_last) begin
        crc        <= ihcv_pkg::ALL_ONES;
        byte_count <= 32'd0;
        phase      <= ihcv_pkg::PH_HEADER;
        err        <= ihcv_pkg::ST_OK;
      end else begin
        crc        <= crc_next;
        byte_count <= count_next;
        phase      <= phase_next;
        err        <= err_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      hlen  <= hlen_next;
      cust  <= cust_next;
      prod  <= prod_next;
      ver   <= ver_next;
      build <= build_next;
      dlen  <= dlen_next;
      dcrc  <= dcrc_next;
      hcrc  <= hcrc_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (proc && proc_res) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (proc && proc_res) begin
      m_axis_tuser <= (phase == ihcv_pkg::PH_PAYLOAD);
      m_axis_tlast <= in_last;
      m_axis_tdata <= res_data;
    end
  end

  // A result without the end mark always carries a payload byte.
  a_plain_is_payload: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser && m_axis_tdata[10:8] == ihcv_pkg::ST_OK)
    else $error("non-final result without payload");

  // The header index never runs past the header.
  a_hdr_index: assert property (@(posedge clk) disable iff (rst)
    phase == ihcv_pkg::PH_HEADER |-> byte_count < ihcv_pkg::HDR_SIZE)
    else $error("header index out of range");

  // An end mark returns the block to the start of a new image.
  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    proc && in_last |=> phase == ihcv_pkg::PH_HEADER && byte_count == 32'd0
                        && crc == ihcv_pkg::ALL_ONES)
    else $error("state not cleared after end mark");

  // A result item is never overwritten before it is taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("pending result lost");

  // Status codes stay within the defined set.
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[10:8] <= ihcv_pkg::ST_DATA_CRC)
    else $error("status code out of range");

endmodule
